### sv/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// shared types and constants of the sorted key table
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int DEPTH   = 64;
    localparam int KEY_W   = 32;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int OCNT_W  = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_REMOVE = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EX,
        S_PUT,
        S_DONE
    } t_state;

    // one write and one read port of the key store
    typedef struct packed {
        logic                    we;
        logic [AW-1:0]           waddr;
        logic signed [KEY_W-1:0] wdata;
        logic                    re;
        logic [AW-1:0]           raddr;
    } t_ram_req;

    // shared compare unit result
    typedef struct packed {
        logic eq;
        logic ge;
    } t_cmp_res;

    // finished result from the sequencer
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [STAT_W-1:0] status;
        logic [OCNT_W-1:0] entry_count;
    } t_result;

endpackage

### sv/skt_if.sv
// ----------------------------------------------------------------------------
// skt_if
// valid/ready channels carrying request and result words
// ----------------------------------------------------------------------------
interface skt_in_if import skt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

interface skt_out_if import skt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [STAT_W-1:0] status;
    logic [OCNT_W-1:0] entry_count;

    modport source (output valid, output found, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input found, input status, input entry_count,
                    output ready);
endinterface

### sv/skt_key_ram.sv
// ----------------------------------------------------------------------------
// skt_key_ram
// key store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module skt_key_ram import skt_pkg::*; (
    input  logic                    i_clk,
    input  t_ram_req                i_req,
    output logic signed [KEY_W-1:0] o_rd_data
);

    logic signed [KEY_W-1:0] mem [DEPTH];
    logic signed [KEY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/skt_cmp.sv
// ----------------------------------------------------------------------------
// skt_cmp
// shared signed compare of a stored key against the request key
// ----------------------------------------------------------------------------
module skt_cmp import skt_pkg::*; (
    input  logic signed [KEY_W-1:0] i_a,
    input  logic signed [KEY_W-1:0] i_b,
    output t_cmp_res                o_res
);

    always_comb begin
        o_res.eq = (i_a == i_b);
        o_res.ge = (i_a >= i_b);
    end

endmodule

### sv/skt_seq.sv
// ----------------------------------------------------------------------------
// skt_seq
// sequencer walking the key store one entry at a time
// ----------------------------------------------------------------------------
module skt_seq import skt_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic [ACT_W-1:0]        i_action,
    input  logic signed [KEY_W-1:0] i_key,
    output logic                    o_in_ready,
    input  logic                    i_res_free,
    output t_result                 o_res,
    output t_ram_req                o_ram_req,
    input  logic signed [KEY_W-1:0] i_rd_data,
    input  t_cmp_res                i_cmp,
    output logic signed [KEY_W-1:0] o_key
);

    t_state                  r_state,  n_state;
    logic [ACT_W-1:0]        r_action, n_action;
    logic signed [KEY_W-1:0] r_key,    n_key;
    logic [CNT_W-1:0]        r_idx,    n_idx;
    logic [CNT_W-1:0]        r_wr,     n_wr;
    logic [CNT_W-1:0]        r_count,  n_count;
    logic                    r_found,  n_found;
    logic [STAT_W-1:0]       r_status, n_status;

    logic [CNT_W-1:0]        idx_dn;
    logic [CNT_W-1:0]        idx_up;
    logic [CNT_W-1:0]        wr_up;

    assign idx_dn = CNT_W'(r_idx - 1'b1);
    assign idx_up = CNT_W'(r_idx + 1'b1);
    assign wr_up  = CNT_W'(r_wr + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_key    <= n_key;
        r_idx    <= n_idx;
        r_wr     <= n_wr;
        r_found  <= n_found;
        r_status <= n_status;
    end

    always_comb begin
        n_state   = r_state;
        n_action  = r_action;
        n_key     = r_key;
        n_idx     = r_idx;
        n_wr      = r_wr;
        n_count   = r_count;
        n_found   = r_found;
        n_status  = r_status;
        o_ram_req = '0;
        o_in_ready = 1'b0;
        o_res     = '0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_action = i_action;
                    n_key    = i_key;
                    n_found  = 1'b0;
                    n_status = ST_OK;
                    n_idx    = '0;
                    n_wr     = '0;
                    case (t_action'(i_action))
                        ACT_INSERT: begin
                            if (r_count >= CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else if (r_count == '0) begin
                                n_state = S_PUT;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_RD;
                            end
                        end
                        ACT_SEARCH, ACT_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end

            S_RD: begin
                o_ram_req.re = 1'b1;
                if (t_action'(r_action) == ACT_INSERT) begin
                    o_ram_req.raddr = idx_dn[AW-1:0];
                end else begin
                    o_ram_req.raddr = r_idx[AW-1:0];
                end
                n_state = S_EX;
            end

            S_EX: begin
                case (t_action'(r_action))
                    ACT_INSERT: begin
                        o_ram_req.we    = 1'b1;
                        o_ram_req.waddr = r_idx[AW-1:0];
                        if (i_cmp.ge) begin
                            // entry not less than key moves up one place
                            o_ram_req.wdata = i_rd_data;
                            n_idx   = idx_dn;
                            n_state = (idx_dn == '0) ? S_PUT : S_RD;
                        end else begin
                            o_ram_req.wdata = r_key;
                            n_count = CNT_W'(r_count + 1'b1);
                            n_state = S_DONE;
                        end
                    end
                    ACT_SEARCH: begin
                        n_idx = idx_up;
                        if (i_cmp.eq) begin
                            n_found = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_state = (idx_up == r_count) ? S_DONE : S_RD;
                        end
                    end
                    ACT_REMOVE: begin
                        n_idx = idx_up;
                        if (i_cmp.eq) begin
                            n_found = 1'b1;
                        end else begin
                            // compact surviving entries toward the bottom
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = r_wr[AW-1:0];
                            o_ram_req.wdata = i_rd_data;
                            n_wr            = wr_up;
                        end
                        if (idx_up == r_count) begin
                            n_count = n_wr;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end

            S_PUT: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_idx[AW-1:0];
                o_ram_req.wdata = r_key;
                n_count = CNT_W'(r_count + 1'b1);
                n_state = S_DONE;
            end

            S_DONE: begin
                o_res.valid       = 1'b1;
                o_res.found       = r_found;
                o_res.status      = r_status;
                o_res.entry_count = OCNT_W'(r_count);
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign o_key = r_key;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_ram_req.we)
        else $error("store written while idle");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("insert did not grow the count");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EX && r_action == ACT_REMOVE) |=> (r_count <= $past(r_count)))
        else $error("remove grew the count");

endmodule

### sv/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// order of work: a full insert, an empty search/remove or an unused action goes straight
//   to the result; an insert moves each entry not less than the key up one place from the
//   top and stops at a smaller entry; a search compares entries from the bottom up to the
//   first match; a remove walks all entries and drops every match
// flow: one request at a time, the next one is taken after the result word is handed on
// reset: synchronous active low, clears the count and the sequencer; keys are not cleared
// ----------------------------------------------------------------------------
module sorted_key_table import skt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    skt_in_if.sink    i_in,
    skt_out_if.source o_out
);

    // sequencer to store, compare unit and output register
    t_ram_req                ram_req;
    logic signed [KEY_W-1:0] rd_data;
    logic signed [KEY_W-1:0] seq_key;
    t_cmp_res                cmp_res;
    t_result                 seq_res;
    logic                    in_ready;

    // output word register, lets the sequencer go on to the next request while the sink stalls
    logic                    r_out_valid;
    logic                    r_found;
    logic [STAT_W-1:0]       r_status;
    logic [OCNT_W-1:0]       r_entry_count;
    logic                    res_free;

    assign res_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = in_ready;

    skt_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_action   (i_in.action),
        .i_key      (i_in.key),
        .o_in_ready (in_ready),
        .i_res_free (res_free),
        .o_res      (seq_res),
        .o_ram_req  (ram_req),
        .i_rd_data  (rd_data),
        .i_cmp      (cmp_res),
        .o_key      (seq_key)
    );

    // stored keys, ascending order
    skt_key_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    // one compare shared by all three actions
    skt_cmp u_cmp (
        .i_a   (rd_data),
        .i_b   (seq_key),
        .o_res (cmp_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_free) begin
            r_out_valid <= seq_res.valid;
        end
    end

    // payload only moves when a finished word is taken in
    always_ff @(posedge i_clk) begin
        if (res_free && seq_res.valid) begin
            r_found       <= seq_res.found;
            r_status      <= seq_res.status;
            r_entry_count <= seq_res.entry_count;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_found;
    assign o_out.status      = r_status;
    assign o_out.entry_count = r_entry_count;

    // no new request while a finished word still waits in the sequencer
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_res.valid |-> !in_ready)
        else $error("request taken while a result is pending");

    // a dropped insert never reports a match
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |-> !r_found)
        else $error("full status with found set");

endmodule
